[hdl/aop_pkg.sv]
// Shared types, field layouts and codes for the box overlap / push-out block.
// No dependencies; every other file in hdl/ imports this package.
package aop_pkg;

	// Q12.8 component width and packed vector layout (x low, then y, then z)
	localparam int COORD_W = 21;
	localparam int VEC_W   = 63;
	localparam int RAD_W   = 46;
	localparam int SCALE_W = 10;
	localparam int CFG_DW  = 64;
	localparam int CFG_AW  = 4;

	localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(2359296);
	localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(282);

	// register index, taken from paddr[3] (registers sit on 8-byte steps)
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_SCALE  = 1'b1;

	localparam logic [1:0] KIND_STATIC  = 2'd0;
	localparam logic [1:0] KIND_DYNAMIC = 2'd1;
	localparam logic [1:0] KIND_ENEMY   = 2'd2;
	localparam logic [1:0] KIND_OTHER   = 2'd3;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z,
		AXIS_NONE
	} axis_t;

	typedef logic [VEC_W-1:0] vec_t;

	// arithmetic types, sized from COORD_W
	typedef logic signed [COORD_W-1:0]   comp_t;  // one component
	typedef logic signed [COORD_W:0]     diff_t;  // b - a, sizes summed
	typedef logic signed [COORD_W+2:0]   ovl_t;   // 2|d| against size sum
	typedef logic signed [2*COORD_W+1:0] sqs_t;   // signed square
	typedef logic        [2*COORD_W:0]   sq_t;    // square magnitude
	typedef logic        [2*COORD_W+2:0] dsum_t;  // sum of three squares
	typedef logic signed [COORD_W+8:0]   geo_t;   // corner / face in Q.16
	typedef logic signed [COORD_W+9:0]   err_t;   // corner minus face
	typedef logic signed [COORD_W+10:0]  prod_t;  // move * scale
	typedef logic signed [COORD_W+11:0]  ps_t;    // pre-move corner minus face
	typedef logic        [COORD_W+2:0]   mag_t;   // push distance in Q12.8
	typedef logic signed [COORD_W+3:0]   np_t;    // new component before clamp

	localparam comp_t COMP_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		vec_t       a_pos;
		vec_t       b_pos;
		vec_t       a_size;
		vec_t       b_size;
		vec_t       a_move;
		vec_t       b_move;
		logic [1:0] a_kind;
		logic [1:0] b_kind;
	} pair_t;

	typedef struct packed {
		logic  event_hit;
		logic  box_overlap;
		logic  push_done;
		logic  pushed_is_b;
		axis_t push_axis;
		vec_t  new_pos;
		vec_t  new_move;
	} result_t;

	typedef struct packed {
		logic [RAD_W-1:0]   radius_sq;
		logic [SCALE_W-1:0] prestep_scale;
	} cfg_t;

	// stage load enables from the pipeline control
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_en_t;

	function automatic comp_t comp_get(input vec_t v, input int k);
		return comp_t'(v[k*COORD_W +: COORD_W]);
	endfunction

endpackage

[hdl/aop_cfg_regs.sv]
// APB-style register file: squared event radius and pre-step scale.
// Depends on aop_pkg.
module aop_cfg_regs
	import aop_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [RAD_W-1:0]   radius_q;
	logic [SCALE_W-1:0] scale_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			scale_q  <= SCALE_RST;
		end else if (wr_en) begin
			case (paddr[3])
				REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_RADIUS: prdata = CFG_DW'(radius_q);
			REG_SCALE:  prdata = CFG_DW'(scale_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.radius_sq     = radius_q;
	assign cfg.prestep_scale = scale_q;

endmodule

[hdl/aop_pipe_ctrl.sv]
// Valid bits and load enables for the four-stage pair pipeline.
// Depends on aop_pkg.
module aop_pipe_ctrl
	import aop_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pair_valid,
	output logic     pair_stall,
	output logic     res_valid,
	input  logic     res_stall,
	output pipe_en_t en
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// a stage loads when empty or when its contents move on this cycle
	always_comb begin
		en.ld_s4 = !vld_s4 || !res_stall;
		en.ld_s3 = !vld_s3 || en.ld_s4;
		en.ld_s2 = !vld_s2 || en.ld_s3;
		en.ld_s1 = !vld_s1 || en.ld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.ld_s1) vld_s1 <= pair_valid;
			if (en.ld_s2) vld_s2 <= vld_s1;
			if (en.ld_s3) vld_s3 <= vld_s2;
			if (en.ld_s4) vld_s4 <= vld_s3;
		end
	end

	assign pair_stall = !en.ld_s1;
	assign res_valid  = vld_s4;

endmodule

[hdl/aop_datapath.sv]
// Four-stage datapath: operand select, squares and products, face crossing,
// push and clamp. Control comes from aop_pipe_ctrl; depends on aop_pkg.
module aop_datapath
	import aop_pkg::*;
(
	input  logic     clk,
	input  pipe_en_t en,
	input  cfg_t     cfg,
	input  pair_t    pair,
	output result_t  res
);

	typedef struct packed {
		logic ovl;
		logic ev;
		logic mover;
		logic is_b;
	} flags_t;

	// stage 1: differences, overlap, mover operands, corner and face
	comp_t  dpos_c [3];
	comp_t  dsize_c [3];
	comp_t  dmove_c [3];
	comp_t  spos_c [3];
	comp_t  ssize_c [3];
	logic   neg_c [3];
	diff_t  diff_c [3];
	diff_t  adiff_c [3];
	logic   ovl_c [3];
	geo_t   lead_c [3];
	geo_t   face_c [3];
	geo_t   dhalf_c [3];
	geo_t   shalf_c [3];
	logic   mva_c, mvb_c;
	flags_t flags_c;

	diff_t  diff_s1 [3];
	comp_t  pos_s1 [3];
	comp_t  mv_s1 [3];
	logic   neg_s1 [3];
	geo_t   lead_s1 [3];
	geo_t   face_s1 [3];
	flags_t flags_s1;

	always_comb begin
		mvb_c = (pair.a_kind == KIND_STATIC) && (pair.b_kind == KIND_DYNAMIC);
		mva_c = (pair.a_kind inside {KIND_DYNAMIC, KIND_ENEMY}) &&
			(pair.b_kind == KIND_STATIC);
		for (int k = 0; k < 3; k++) begin
			dpos_c[k]  = mvb_c ? comp_get(pair.b_pos, k)  : comp_get(pair.a_pos, k);
			dsize_c[k] = mvb_c ? comp_get(pair.b_size, k) : comp_get(pair.a_size, k);
			dmove_c[k] = mvb_c ? comp_get(pair.b_move, k) : comp_get(pair.a_move, k);
			spos_c[k]  = mvb_c ? comp_get(pair.a_pos, k)  : comp_get(pair.b_pos, k);
			ssize_c[k] = mvb_c ? comp_get(pair.a_size, k) : comp_get(pair.b_size, k);
			// zero move counts as the negative direction
			neg_c[k]   = dmove_c[k][COORD_W-1] || (dmove_c[k] == '0);

			diff_c[k]  = diff_t'(comp_get(pair.b_pos, k)) - diff_t'(comp_get(pair.a_pos, k));
			adiff_c[k] = diff_c[k][COORD_W] ? -diff_c[k] : diff_c[k];
			ovl_c[k]   = (ovl_t'(adiff_c[k]) <<< 1) <
				(ovl_t'(comp_get(pair.a_size, k)) + ovl_t'(comp_get(pair.b_size, k)));

			dhalf_c[k] = geo_t'(dsize_c[k]) <<< 7;
			shalf_c[k] = geo_t'(ssize_c[k]) <<< 7;
			lead_c[k]  = (geo_t'(dpos_c[k]) <<< 8) + (neg_c[k] ? -dhalf_c[k] : dhalf_c[k]);
			face_c[k]  = (geo_t'(spos_c[k]) <<< 8) + (neg_c[k] ? shalf_c[k] : -shalf_c[k]);
		end
		flags_c.ovl   = ovl_c[0] && ovl_c[1] && ovl_c[2];
		flags_c.ev    = (pair.a_kind == KIND_DYNAMIC) && (pair.b_kind == KIND_ENEMY);
		flags_c.mover = flags_c.ovl && (mva_c || mvb_c);
		flags_c.is_b  = mvb_c;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= diff_c[k];
				pos_s1[k]  <= dpos_c[k];
				mv_s1[k]   <= dmove_c[k];
				neg_s1[k]  <= neg_c[k];
				lead_s1[k] <= lead_c[k];
				face_s1[k] <= face_c[k];
			end
			flags_s1 <= flags_c;
		end
	end

	// stage 2: squares, corner-to-face error, pre-step products
	sqs_t   sqs_c [3];
	sq_t    sq_s2 [3];
	err_t   err_s2 [3];
	prod_t  prod_s2 [3];
	comp_t  pos_s2 [3];
	comp_t  mv_s2 [3];
	logic   neg_s2 [3];
	flags_t flags_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sqs_c[k] = sqs_t'(diff_s1[k]) * sqs_t'(diff_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k]   <= sqs_c[k][2*COORD_W:0];
				err_s2[k]  <= err_t'(lead_s1[k]) - err_t'(face_s1[k]);
				prod_s2[k] <= prod_t'(mv_s1[k]) * prod_t'(cfg.prestep_scale);
				pos_s2[k]  <= pos_s1[k];
				mv_s2[k]   <= mv_s1[k];
				neg_s2[k]  <= neg_s1[k];
			end
			flags_s2 <= flags_s1;
		end
	end

	// stage 3: radius compare, face crossing, rounded push distance
	dsum_t             dsum_c;
	ps_t               ps_c [3];
	logic              cross_c [3];
	logic [COORD_W+9:0] aerr_c [3];
	logic [COORD_W+10:0] rnd_c [3];

	logic   hit_s3;
	logic   cross_s3 [3];
	mag_t   mag_s3 [3];
	comp_t  pos_s3 [3];
	comp_t  mv_s3 [3];
	logic   neg_s3 [3];
	flags_t flags_s3;

	always_comb begin
		dsum_c = dsum_t'(sq_s2[0]) + dsum_t'(sq_s2[1]) + dsum_t'(sq_s2[2]);
		for (int k = 0; k < 3; k++) begin
			ps_c[k]    = ps_t'(err_s2[k]) - ps_t'(prod_s2[k]);
			// crossed when before and after lie strictly on opposite sides
			cross_c[k] = (ps_c[k] != '0) && (err_s2[k] != '0) &&
				(ps_c[k][COORD_W+11] != err_s2[k][COORD_W+9]);
			aerr_c[k]  = err_s2[k][COORD_W+9] ? -err_s2[k] : err_s2[k];
			rnd_c[k]   = {1'b0, aerr_c[k]} + (COORD_W+11)'(255);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			hit_s3 <= flags_s2.ev && (RAD_W'(dsum_c) <= cfg.radius_sq);
			for (int k = 0; k < 3; k++) begin
				cross_s3[k] <= cross_c[k];
				mag_s3[k]   <= rnd_c[k][COORD_W+10:8];
				pos_s3[k]   <= pos_s2[k];
				mv_s3[k]    <= mv_s2[k];
				neg_s3[k]   <= neg_s2[k];
			end
			flags_s3 <= flags_s2;
		end
	end

	// stage 4: first crossed axis, push with clamp, pack result
	logic    sel_c [3];
	np_t     np_c [3];
	comp_t   clamp_c [3];
	axis_t   axis_c;
	result_t res_c;

	always_comb begin
		sel_c[0] = cross_s3[0];
		sel_c[1] = !cross_s3[0] && cross_s3[1];
		sel_c[2] = !cross_s3[0] && !cross_s3[1] && cross_s3[2];
		if (sel_c[0])      axis_c = AXIS_X;
		else if (sel_c[1]) axis_c = AXIS_Y;
		else if (sel_c[2]) axis_c = AXIS_Z;
		else               axis_c = AXIS_NONE;

		res_c             = '0;
		res_c.event_hit   = hit_s3;
		res_c.box_overlap = flags_s3.ovl;
		res_c.push_axis   = AXIS_NONE;
		for (int k = 0; k < 3; k++) begin
			np_c[k] = np_t'(pos_s3[k]) + (neg_s3[k] ? np_t'(mag_s3[k]) : -np_t'(mag_s3[k]));
			if (np_c[k] > np_t'(COMP_MAX))      clamp_c[k] = COMP_MAX;
			else if (np_c[k] < np_t'(COMP_MIN)) clamp_c[k] = COMP_MIN;
			else                                clamp_c[k] = np_c[k][COORD_W-1:0];
		end
		if (flags_s3.mover) begin
			res_c.push_done   = (axis_c != AXIS_NONE);
			res_c.pushed_is_b = flags_s3.is_b;
			res_c.push_axis   = axis_c;
			for (int k = 0; k < 3; k++) begin
				res_c.new_pos[k*COORD_W +: COORD_W]  = sel_c[k] ? clamp_c[k] : pos_s3[k];
				res_c.new_move[k*COORD_W +: COORD_W] = sel_c[k] ? '0 : mv_s3[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			res <= res_c;
		end
	end

endmodule

[hdl/aabb_overlap_push_resolver.sv]
// Box overlap and push-out resolver for object pairs. Takes one pair beat per
// clock while pair_stall is low; each result beat passes through the four
// register stages of the datapath (select, multiply, compare, push), and a
// stall on the result side holds every occupied stage so nothing is dropped.
// Registers: event radius squared at byte 0x0, pre-step scale at 0x8, write
// them only while no pair is in flight.
// Depends on aop_pkg, aop_cfg_regs, aop_pipe_ctrl and aop_datapath.
module aabb_overlap_push_resolver
	import aop_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_stall,
	input  pair_t             pair,
	output logic              res_valid,
	input  logic              res_stall,
	output result_t           res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg;
	pipe_en_t en;

	aop_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aop_pipe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.en         (en)
	);

	aop_datapath u_dp (
		.clk  (clk),
		.en   (en),
		.cfg  (cfg),
		.pair (pair),
		.res  (res)
	);

endmodule

[tb/aabb_overlap_push_resolver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for aabb_overlap_push_resolver: pair beats in, result beats out.
// Predicts each result from its own copy of the two registers; needs only aop_pkg and the RTL.
module aabb_overlap_push_resolver_tb;
	import aop_pkg::*;

	localparam longint CMAX = longint'(COMP_MAX);
	localparam longint CMIN = longint'(COMP_MIN);
	localparam longint LIMIT_CYCLES = 200000;
	localparam logic [CFG_AW-1:0] ADDR_RADIUS = 4'h0;
	localparam logic [CFG_AW-1:0] ADDR_SCALE  = 4'h8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              pair_valid = 1'b0;
	logic              pair_stall;
	pair_t             pair = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	result_t           res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	// predictor's copy of the registers
	logic [RAD_W-1:0]   radius_sq_cfg = RADIUS_RST;
	logic [SCALE_W-1:0] scale_cfg = SCALE_RST;

	result_t result_due[$];
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      hold_len = 0;
	int      hold_cnt = 0;
	int      mismatches = 0;
	longint  cycles = 0;

	aabb_overlap_push_resolver DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- vector helpers ----------------

	function automatic longint coord(input vec_t v, input int k);
		logic signed [COORD_W-1:0] c;
		c = v[k*COORD_W +: COORD_W];
		return longint'(c);
	endfunction

	function automatic vec_t mkvec(input longint x, input longint y, input longint z);
		vec_t v;
		v[COORD_W-1:0]           = x[COORD_W-1:0];
		v[2*COORD_W-1:COORD_W]   = y[COORD_W-1:0];
		v[3*COORD_W-1:2*COORD_W] = z[COORD_W-1:0];
		return v;
	endfunction

	function automatic vec_t on_axis(input int k, input longint v);
		return mkvec(k == 0 ? v : 0, k == 1 ? v : 0, k == 2 ? v : 0);
	endfunction

	// ---------------- predictor ----------------

	// push the mover out of the static box along the first crossed face
	function automatic result_t push_mover(input vec_t dpos, input vec_t dsize, input vec_t dmove,
			input vec_t spos, input vec_t ssize);
		result_t r;
		longint  pos[3];
		longint  mv[3];
		longint  dir, d, s, pre, depth, np;
		int      k;
		r = '0;
		r.push_axis = AXIS_NONE;
		for (k = 0; k < 3; k++) begin
			pos[k] = coord(dpos, k);
			mv[k]  = coord(dmove, k);
		end
		for (k = 0; k < 3; k++) begin
			if (r.push_axis == AXIS_NONE) begin
				dir = (mv[k] > 0) ? 1 : -1;
				// corner and face in Q.16
				d   = pos[k] * 256 + dir * coord(dsize, k) * 128;
				s   = coord(spos, k) * 256 - dir * coord(ssize, k) * 128;
				pre = d - mv[k] * longint'(scale_cfg);
				if (pre != s && d != s && ((pre > s) != (d > s))) begin
					depth = (d > s) ? d - s : s - d;
					depth = (depth + 255) / 256;
					np = pos[k] - dir * depth;
					if (np > CMAX)
						np = CMAX;
					if (np < CMIN)
						np = CMIN;
					pos[k] = np;
					mv[k] = 0;
					r.push_axis = axis_t'(k);
					r.push_done = 1'b1;
				end
			end
		end
		r.new_pos  = mkvec(pos[0], pos[1], pos[2]);
		r.new_move = mkvec(mv[0], mv[1], mv[2]);
		return r;
	endfunction

	function automatic result_t resolve_pair(input pair_t p);
		result_t r;
		longint  dd, dist_sq;
		logic    overlap;
		int      k;
		dist_sq = 0;
		overlap = 1'b1;
		for (k = 0; k < 3; k++) begin
			dd = coord(p.b_pos, k) - coord(p.a_pos, k);
			dist_sq += dd * dd;
			if (!(2 * (dd < 0 ? -dd : dd) < coord(p.a_size, k) + coord(p.b_size, k)))
				overlap = 1'b0;
		end
		r = '0;
		r.push_axis = AXIS_NONE;
		if (overlap && (p.a_kind == KIND_DYNAMIC || p.a_kind == KIND_ENEMY) &&
				p.b_kind == KIND_STATIC) begin
			r = push_mover(p.a_pos, p.a_size, p.a_move, p.b_pos, p.b_size);
		end else if (overlap && p.a_kind == KIND_STATIC && p.b_kind == KIND_DYNAMIC) begin
			r = push_mover(p.b_pos, p.b_size, p.b_move, p.a_pos, p.a_size);
			r.pushed_is_b = 1'b1;
		end
		r.event_hit = (dist_sq <= longint'(radius_sq_cfg)) && p.a_kind == KIND_DYNAMIC &&
			p.b_kind == KIND_ENEMY;
		r.box_overlap = overlap;
		return r;
	endfunction

	// ---------------- stimulus builders ----------------

	function automatic pair_t make_pair(input vec_t ap, input vec_t bp, input vec_t a_sz,
			input vec_t b_sz, input vec_t am, input vec_t bm, input logic [1:0] ak,
			input logic [1:0] bk);
		pair_t p;
		p.a_pos  = ap;
		p.b_pos  = bp;
		p.a_size = a_sz;
		p.b_size = b_sz;
		p.a_move = am;
		p.b_move = bm;
		p.a_kind = ak;
		p.b_kind = bk;
		return p;
	endfunction

	function automatic longint rand_span(input longint lim);
		return longint'($urandom_range(int'(2 * lim))) - lim;
	endfunction

	function automatic vec_t rand_bits();
		return vec_t'({$urandom, $urandom});
	endfunction

	// boxes placed within 64 LSBs of touching or overlapping, moves of up to 1500 LSBs in magnitude
	function automatic pair_t gen_contact();
		longint ap[3], bp[3], a_sz[3], b_sz[3], am[3], bm[3];
		logic [1:0] ak, bk;
		int k;
		for (k = 0; k < 3; k++) begin
			a_sz[k] = ($urandom_range(9) == 0) ? longint'($urandom_range(int'(CMAX))) :
				longint'($urandom_range(4096, 1));
			b_sz[k] = longint'($urandom_range(4096, 1));
			case ($urandom_range(9))
				0: ap[k] = CMAX - longint'($urandom_range(2000));
				1: ap[k] = CMIN + longint'($urandom_range(2000));
				2: ap[k] = rand_span(CMAX);
				default: ap[k] = rand_span(200000);
			endcase
			bp[k] = ap[k] + rand_span((a_sz[k] + b_sz[k]) / 2 + 64);
			am[k] = ($urandom_range(3) == 0) ? 0 : rand_span(1500);
			bm[k] = ($urandom_range(3) == 0) ? 0 : rand_span(1500);
		end
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				ak = $urandom_range(1) ? KIND_DYNAMIC : KIND_ENEMY;
				bk = KIND_STATIC;
			end
			4, 5, 6: begin
				ak = KIND_STATIC;
				bk = KIND_DYNAMIC;
			end
			7: begin
				ak = KIND_DYNAMIC;
				bk = KIND_ENEMY;
			end
			default: begin
				ak = 2'($urandom_range(3));
				bk = 2'($urandom_range(3));
			end
		endcase
		return make_pair(mkvec(ap[0], ap[1], ap[2]), mkvec(bp[0], bp[1], bp[2]),
			mkvec(a_sz[0], a_sz[1], a_sz[2]), mkvec(b_sz[0], b_sz[1], b_sz[2]),
			mkvec(am[0], am[1], am[2]), mkvec(bm[0], bm[1], bm[2]), ak, bk);
	endfunction

	function automatic pair_t gen_pair();
		pair_t p;
		longint x, y, z;
		case ($urandom_range(19))
			0, 1, 2: begin
				// dynamic vs enemy around the event radius
				p = gen_contact();
				x = coord(p.a_pos, 0);
				y = coord(p.a_pos, 1);
				z = coord(p.a_pos, 2);
				p.b_pos = mkvec(x + rand_span(2048), y + rand_span(2048), z + rand_span(2048));
				p.a_kind = KIND_DYNAMIC;
				p.b_kind = KIND_ENEMY;
			end
			3, 4, 5, 6:
				p = make_pair(rand_bits(), rand_bits(), rand_bits(), rand_bits(), rand_bits(),
					rand_bits(), 2'($urandom_range(3)), 2'($urandom_range(3)));
			default:
				p = gen_contact();
		endcase
		return p;
	endfunction

	// ---------------- drivers ----------------

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_pair(input pair_t p);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		result_due.push_back(resolve_pair(p));
		@(negedge clk);
	endtask

	// drop valid and wait until every expected result beat has been taken
	task automatic drain_results();
		pair_valid <= 1'b0;
		@(negedge clk);
		while (result_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SCALE)
			scale_cfg = data[SCALE_W-1:0];
		else
			radius_sq_cfg = data[RAD_W-1:0];
	endtask

	// receiver: random stall, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_len != 0) begin
			hold_cnt = hold_len;
			hold_len = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------- checking ----------------

	task automatic check_field(input string name, input logic [VEC_W-1:0] want,
			input logic [VEC_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (result_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat expected none actual %h", $time, res);
			end else begin
				want = result_due.pop_front();
				check_field("event_hit", VEC_W'(want.event_hit), VEC_W'(res.event_hit));
				check_field("box_overlap", VEC_W'(want.box_overlap), VEC_W'(res.box_overlap));
				check_field("push_done", VEC_W'(want.push_done), VEC_W'(res.push_done));
				check_field("pushed_is_b", VEC_W'(want.pushed_is_b), VEC_W'(res.pushed_is_b));
				check_field("push_axis", VEC_W'(want.push_axis), VEC_W'(res.push_axis));
				check_field("new_pos", want.new_pos, res.new_pos);
				check_field("new_move", want.new_move, res.new_move);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// reset register values, field extremes, pushing and non-pushing kind pairings, push on each axis
	task automatic test_directed();
		vec_t unit2;
		vec_t ones;
		int   k;
		unit2 = mkvec(512, 512, 512);
		ones  = {VEC_W{1'b1}};
		send_idle_pct = 0;
		stall_pct = 0;
		send_pair(make_pair('0, '0, '0, '0, '0, '0, KIND_STATIC, KIND_STATIC));
		send_pair(make_pair(ones, ones, ones, ones, ones, ones, KIND_OTHER, KIND_OTHER));
		send_pair(make_pair(mkvec(CMAX, CMAX, CMAX), mkvec(CMIN, CMIN, CMIN),
			mkvec(CMAX, CMAX, CMAX), mkvec(CMAX, CMAX, CMAX), mkvec(CMIN, CMIN, CMIN),
			mkvec(CMAX, CMAX, CMAX), KIND_DYNAMIC, KIND_ENEMY));
		// sphere edge: exactly six units apart, then one LSB further
		send_pair(make_pair('0, on_axis(0, 1536), unit2, unit2, '0, '0, KIND_DYNAMIC,
			KIND_ENEMY));
		send_pair(make_pair('0, on_axis(0, 1537), unit2, unit2, '0, '0, KIND_DYNAMIC,
			KIND_ENEMY));
		send_pair(make_pair('0, on_axis(1, -100), unit2, unit2, '0, '0, KIND_ENEMY,
			KIND_DYNAMIC));
		// A dynamic pushed out on each axis
		for (k = 0; k < 3; k++)
			send_pair(make_pair('0, on_axis(k, 400), unit2, unit2, on_axis(k, 200), '0,
				KIND_DYNAMIC, KIND_STATIC));
		// enemy mover going negative, B as mover
		send_pair(make_pair('0, on_axis(1, -400), unit2, unit2, on_axis(1, -200), '0,
			KIND_ENEMY, KIND_STATIC));
		send_pair(make_pair('0, on_axis(2, 400), unit2, unit2, '0, on_axis(2, -200),
			KIND_STATIC, KIND_DYNAMIC));
		// mover but no face crossed (zero moves)
		send_pair(make_pair('0, mkvec(100, 100, 100), unit2, unit2, '0, '0, KIND_DYNAMIC,
			KIND_STATIC));
		send_pair(make_pair('0, mkvec(100, 100, 100), unit2, unit2, '0, '0, KIND_STATIC,
			KIND_DYNAMIC));
		// kind pairs that never push
		send_pair(make_pair('0, on_axis(0, 400), unit2, unit2, on_axis(0, 200), '0,
			KIND_OTHER, KIND_STATIC));
		send_pair(make_pair('0, on_axis(0, 400), unit2, unit2, on_axis(0, 200), '0,
			KIND_DYNAMIC, KIND_OTHER));
		send_pair(make_pair('0, on_axis(0, 400), unit2, unit2, '0, on_axis(0, -200),
			KIND_STATIC, KIND_ENEMY));
		send_pair(make_pair('0, on_axis(0, 400), unit2, unit2, '0, on_axis(0, -200),
			KIND_STATIC, KIND_STATIC));
		send_pair(make_pair('0, on_axis(0, 400), unit2, unit2, on_axis(0, 200), '0,
			KIND_ENEMY, KIND_ENEMY));
		// boxes exactly touching, and negative sizes
		send_pair(make_pair('0, on_axis(0, 512), unit2, unit2, on_axis(0, 200), '0,
			KIND_DYNAMIC, KIND_STATIC));
		send_pair(make_pair('0, '0, mkvec(-512, -512, -512), unit2, '0, '0, KIND_DYNAMIC,
			KIND_STATIC));
		// push that runs past the top and bottom of the coordinate range
		send_pair(make_pair(mkvec(CMAX - 5, 0, 0), mkvec(CMAX - 135, 0, 0),
			mkvec(200, 100, 100), mkvec(100, 100, 100), on_axis(0, -50), '0,
			KIND_DYNAMIC, KIND_STATIC));
		send_pair(make_pair(mkvec(CMIN + 5, 0, 0), mkvec(CMIN + 135, 0, 0),
			mkvec(200, 100, 100), mkvec(100, 100, 100), on_axis(0, 50), '0,
			KIND_DYNAMIC, KIND_STATIC));
		drain_results();
	endtask

	task automatic test_phase(input logic [CFG_DW-1:0] radius, input logic [CFG_DW-1:0] scale,
			input int send_pct, input int rx_pct, input int count);
		int n;
		drain_results();
		write_reg(ADDR_RADIUS, radius);
		write_reg(ADDR_SCALE, scale);
		send_idle_pct = send_pct;
		stall_pct = rx_pct;
		for (n = 0; n < count; n++)
			send_pair(gen_pair());
		drain_results();
	endtask

	// receiver holds off long enough for the block to fill and stall the sender
	task automatic test_backpressure();
		int n;
		send_idle_pct = 0;
		hold_len = 300;
		for (n = 0; n < 40; n++)
			send_pair(gen_pair());
		drain_results();
	endtask

	// sender stops mid-stream until every result has come back
	task automatic test_drain_pause();
		int n;
		send_idle_pct = 23;
		stall_pct = 23;
		for (n = 0; n < 30; n++)
			send_pair(gen_pair());
		drain_results();
		for (n = 0; n < 30; n++)
			send_pair(gen_pair());
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_phase({{(CFG_DW-RAD_W){1'b0}}, {RAD_W{1'b1}}}, 64'd1023, 0, 0, 200);
		test_phase(64'd0, 64'd0, 82, 0, 200);
		test_phase({$urandom, $urandom}, {$urandom, $urandom}, 0, 82, 200);
		test_phase(64'(RADIUS_RST), 64'(SCALE_RST), 23, 23, 200);
		test_backpressure();
		test_drain_pause();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && result_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
hdl/aop_pkg.sv
hdl/aop_cfg_regs.sv
hdl/aop_pipe_ctrl.sv
hdl/aop_datapath.sv
hdl/aabb_overlap_push_resolver.sv
tb/aabb_overlap_push_resolver_tb.sv
